>>> hw/rtl/pgtm_pkg.sv
// ----------------------------------------------------------------------------
// pgtm_pkg: shared types and constants for the packed GEMM tile MAC
// Command codes, register map, state encoding and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtm_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PIDX_W  = 7;   // packed store address
  localparam int unsigned LINE_W  = 3;   // row / column index
  localparam int unsigned SIZE_W  = 4;   // rows_in_use / cols_in_use
  localparam int unsigned DEPTH_W = 5;   // depth_in_use
  localparam int unsigned WORD_W  = 16;  // packed A/B word, Q8.8
  localparam int unsigned CVAL_W  = 32;  // C entry, Q16.16
  localparam int unsigned CIDX_W  = 2 * LINE_W;
  localparam int unsigned PACK_DEPTH = 2 ** PIDX_W;
  localparam int unsigned C_DEPTH    = 2 ** CIDX_W;
  localparam int unsigned FRAC_W  = 8;   // truncation after alpha scaling

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Commands carried in the input tuser
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_C  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] REG_ROWS      = 3'd0;
  localparam logic [2:0] REG_COLS      = 3'd1;
  localparam logic [2:0] REG_DEPTH     = 3'd2;
  localparam logic [2:0] REG_ALPHA     = 3'd3;
  localparam logic [2:0] REG_OVERWRITE = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_SUM   = 5'b10000
  } pgtm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;      // load transfer accepted this cycle
    logic              issue;     // read A, B and C for one k step
    logic              clr_acc;   // first k step of an entry
    logic              scale_en;  // multiply sum by alpha
    logic              emit;      // write back C and fill output register
    logic              last;      // final entry of the tile
    logic [LINE_W-1:0] row;
    logic [LINE_W-1:0] col;
    logic [DEPTH_W-1:0] k;
  } pgtm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } pgtm_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/pgtm_cfg.sv
// ----------------------------------------------------------------------------
// pgtm_cfg: configuration register file
// APB-style write/read of the five tile registers and clamping of the sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_cfg #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned MAX_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pgtm_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [pgtm_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [pgtm_pkg::APB_DATA_W-1:0]      prdata,
  output logic      [pgtm_pkg::SIZE_W-1:0]          bm,
  output logic      [pgtm_pkg::SIZE_W-1:0]          bn,
  output logic      [pgtm_pkg::DEPTH_W-1:0]         bk,
  output logic      [pgtm_pkg::WORD_W-1:0]          alpha,
  output logic                                      overwrite
);

  localparam int unsigned DEPTH_CAP =
    (MAX_DEPTH < (2 ** pgtm_pkg::DEPTH_W) - 1) ? MAX_DEPTH : (2 ** pgtm_pkg::DEPTH_W) - 1;

  logic [pgtm_pkg::SIZE_W-1:0]  rows_r;
  logic [pgtm_pkg::SIZE_W-1:0]  cols_r;
  logic [pgtm_pkg::DEPTH_W-1:0] depth_r;
  logic [pgtm_pkg::WORD_W-1:0]  alpha_r;
  logic                         overwrite_r;
  logic                         wr_en;
  logic [2:0]                   reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= pgtm_pkg::SIZE_W'(8);
      cols_r      <= pgtm_pkg::SIZE_W'(8);
      depth_r     <= pgtm_pkg::DEPTH_W'(16);
      alpha_r     <= pgtm_pkg::WORD_W'(256);
      overwrite_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        pgtm_pkg::REG_ROWS:      rows_r      <= pwdata[pgtm_pkg::SIZE_W-1:0];
        pgtm_pkg::REG_COLS:      cols_r      <= pwdata[pgtm_pkg::SIZE_W-1:0];
        pgtm_pkg::REG_DEPTH:     depth_r     <= pwdata[pgtm_pkg::DEPTH_W-1:0];
        pgtm_pkg::REG_ALPHA:     alpha_r     <= pwdata[pgtm_pkg::WORD_W-1:0];
        pgtm_pkg::REG_OVERWRITE: overwrite_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pgtm_pkg::REG_ROWS:      prdata = pgtm_pkg::APB_DATA_W'(rows_r);
      pgtm_pkg::REG_COLS:      prdata = pgtm_pkg::APB_DATA_W'(cols_r);
      pgtm_pkg::REG_DEPTH:     prdata = pgtm_pkg::APB_DATA_W'(depth_r);
      pgtm_pkg::REG_ALPHA:     prdata = pgtm_pkg::APB_DATA_W'($signed(alpha_r));
      pgtm_pkg::REG_OVERWRITE: prdata = pgtm_pkg::APB_DATA_W'(overwrite_r);
      default:                 prdata = '0;
    endcase
  end

  // Zero reads as one, anything above the maximum reads as the maximum
  always_comb begin
    if (rows_r == '0) begin
      bm = pgtm_pkg::SIZE_W'(1);
    end else if (rows_r > pgtm_pkg::SIZE_W'(MAX_ROWS)) begin
      bm = pgtm_pkg::SIZE_W'(MAX_ROWS);
    end else begin
      bm = rows_r;
    end
    if (cols_r == '0) begin
      bn = pgtm_pkg::SIZE_W'(1);
    end else if (cols_r > pgtm_pkg::SIZE_W'(MAX_COLS)) begin
      bn = pgtm_pkg::SIZE_W'(MAX_COLS);
    end else begin
      bn = cols_r;
    end
    if (depth_r == '0) begin
      bk = pgtm_pkg::DEPTH_W'(1);
    end else if (depth_r > pgtm_pkg::DEPTH_W'(DEPTH_CAP)) begin
      bk = pgtm_pkg::DEPTH_W'(DEPTH_CAP);
    end else begin
      bk = depth_r;
    end
  end

  assign alpha     = alpha_r;
  assign overwrite = overwrite_r;

endmodule

`default_nettype wire

>>> hw/rtl/pgtm_ctrl.sv
// ----------------------------------------------------------------------------
// pgtm_ctrl: tile sequencer
// Walks columns, rows and the inner dimension and steers the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic [pgtm_pkg::CMD_W-1:0]         in_cmd,
  output logic                                    in_ready,
  input  wire logic [pgtm_pkg::SIZE_W-1:0]        bm,
  input  wire logic [pgtm_pkg::SIZE_W-1:0]        bn,
  input  wire logic [pgtm_pkg::DEPTH_W-1:0]       bk,
  input  wire pgtm_pkg::pgtm_stat_t               stat,
  output pgtm_pkg::pgtm_cmd_t                     cmd
);

  pgtm_pkg::pgtm_state_t              state_r, state_nxt;
  logic [pgtm_pkg::LINE_W-1:0]        row_r, row_nxt;
  logic [pgtm_pkg::LINE_W-1:0]        col_r, col_nxt;
  logic [pgtm_pkg::DEPTH_W-1:0]       k_r, k_nxt;
  logic                               accept;
  logic                               row_end;
  logic                               col_end;

  assign in_ready = (state_r == pgtm_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign row_end  = ({1'b0, row_r} == bm - pgtm_pkg::SIZE_W'(1));
  assign col_end  = ({1'b0, col_r} == bn - pgtm_pkg::SIZE_W'(1));

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    cmd          = '0;
    cmd.row      = row_r;
    cmd.col      = col_r;
    cmd.k        = k_r;
    cmd.last     = row_end & col_end;
    cmd.load     = accept & (in_cmd != pgtm_pkg::CMD_COMPUTE);
    case (state_r)
      pgtm_pkg::ST_IDLE: begin
        if (accept && in_cmd == pgtm_pkg::CMD_COMPUTE) begin
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
          state_nxt = pgtm_pkg::ST_MAC;
        end
      end
      pgtm_pkg::ST_MAC: begin
        cmd.issue   = 1'b1;
        cmd.clr_acc = (k_r == '0);
        if (k_r == bk - pgtm_pkg::DEPTH_W'(1)) begin
          k_nxt     = '0;
          state_nxt = pgtm_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + pgtm_pkg::DEPTH_W'(1);
        end
      end
      pgtm_pkg::ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = pgtm_pkg::ST_SCALE;
        end
      end
      pgtm_pkg::ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = pgtm_pkg::ST_SUM;
      end
      pgtm_pkg::ST_SUM: begin
        // Hold until the output register can take the entry
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (row_end && col_end) begin
            state_nxt = pgtm_pkg::ST_IDLE;
          end else begin
            state_nxt = pgtm_pkg::ST_MAC;
            if (row_end) begin
              row_nxt = '0;
              col_nxt = col_r + pgtm_pkg::LINE_W'(1);
            end else begin
              row_nxt = row_r + pgtm_pkg::LINE_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = pgtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgtm_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pgtm_dp.sv
// ----------------------------------------------------------------------------
// pgtm_dp: tile datapath
// Packed A/B stores, C tile store, MAC pipeline, alpha scaling, saturation
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_dp #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pgtm_pkg::pgtm_cmd_t                cmd,
  output pgtm_pkg::pgtm_stat_t                    stat,
  input  wire logic [pgtm_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [pgtm_pkg::PIDX_W-1:0]        in_pidx,
  input  wire logic [pgtm_pkg::LINE_W-1:0]        in_row,
  input  wire logic [pgtm_pkg::LINE_W-1:0]        in_col,
  input  wire logic [pgtm_pkg::CVAL_W-1:0]        in_value,
  input  wire logic [pgtm_pkg::SIZE_W-1:0]        bm,
  input  wire logic [pgtm_pkg::SIZE_W-1:0]        bn,
  input  wire logic [pgtm_pkg::DEPTH_W-1:0]       bk,
  input  wire logic [pgtm_pkg::WORD_W-1:0]        alpha,
  input  wire logic                               overwrite,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [pgtm_pkg::LINE_W-1:0]        out_row,
  output logic      [pgtm_pkg::LINE_W-1:0]        out_col,
  output logic      [pgtm_pkg::CVAL_W-1:0]        out_value,
  output logic                                    out_last
);

  localparam int unsigned DEPTH_CAP =
    (MAX_DEPTH < (2 ** pgtm_pkg::DEPTH_W) - 1) ? MAX_DEPTH : (2 ** pgtm_pkg::DEPTH_W) - 1;
  localparam int unsigned PROD_W = 2 * pgtm_pkg::WORD_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(DEPTH_CAP + 1);
  localparam int unsigned SCL_W  = ACC_W + pgtm_pkg::WORD_W;
  localparam int unsigned SH_W   = SCL_W - pgtm_pkg::FRAC_W;
  localparam int unsigned SUM_W  = SH_W + 1;

  // Packed address of element (line, k) in a panel of n lines
  function automatic logic [pgtm_pkg::PIDX_W-1:0] packed_addr(
    input logic [pgtm_pkg::LINE_W-1:0]  line,
    input logic [pgtm_pkg::DEPTH_W-1:0] k,
    input logic [pgtm_pkg::SIZE_W-1:0]  n,
    input logic [pgtm_pkg::DEPTH_W-1:0] depth
  );
    logic [7:0] pair_base;
    logic [7:0] offs;
    logic [7:0] full;
    logic       odd_tail;
    pair_base = (8'(line[2:1]) * 8'(depth)) << 1;
    odd_tail  = n[0] & ({1'b0, line} == n - pgtm_pkg::SIZE_W'(1));
    offs      = odd_tail ? 8'(k) : {2'b00, k, line[0]};
    full      = pair_base + offs;
    return full[pgtm_pkg::PIDX_W-1:0];
  endfunction

  logic [pgtm_pkg::WORD_W-1:0] a_mem [pgtm_pkg::PACK_DEPTH];
  logic [pgtm_pkg::WORD_W-1:0] b_mem [pgtm_pkg::PACK_DEPTH];
  logic [pgtm_pkg::CVAL_W-1:0] c_mem [pgtm_pkg::C_DEPTH];

  logic [pgtm_pkg::PIDX_W-1:0] a_addr;
  logic [pgtm_pkg::PIDX_W-1:0] b_addr;
  logic [pgtm_pkg::CIDX_W-1:0] c_wr_addr;
  logic [pgtm_pkg::CVAL_W-1:0] c_wr_data;
  logic                        c_wr_en;

  logic [pgtm_pkg::WORD_W-1:0] a_q_r;
  logic [pgtm_pkg::WORD_W-1:0] b_q_r;
  logic [pgtm_pkg::CVAL_W-1:0] c_q_r;
  logic                        v1_r;
  logic                        v2_r;
  logic [PROD_W-1:0]           prod_r;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic [SCL_W-1:0]            scaled_r;
  logic [SH_W-1:0]             shifted;
  logic [pgtm_pkg::CVAL_W-1:0] base;
  logic [SUM_W-1:0]            total;
  logic [pgtm_pkg::CVAL_W-1:0] result;
  logic                        in_range;

  logic                        out_valid_r, out_valid_nxt;
  logic [pgtm_pkg::LINE_W-1:0] out_row_r;
  logic [pgtm_pkg::LINE_W-1:0] out_col_r;
  logic [pgtm_pkg::CVAL_W-1:0] out_value_r;
  logic                        out_last_r;

  assign a_addr = packed_addr(cmd.row, cmd.k, bm, bk);
  assign b_addr = packed_addr(cmd.col, cmd.k, bn, bk);

  // Packed stores: one write port from loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && in_cmd == pgtm_pkg::CMD_LOAD_A) begin
      a_mem[in_pidx] <= in_value[pgtm_pkg::WORD_W-1:0];
    end
    if (cmd.issue) begin
      a_q_r <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_cmd == pgtm_pkg::CMD_LOAD_B) begin
      b_mem[in_pidx] <= in_value[pgtm_pkg::WORD_W-1:0];
    end
    if (cmd.issue) begin
      b_q_r <= b_mem[b_addr];
    end
  end

  // C tile: loads and write-back share the write port
  assign c_wr_en   = (cmd.load && in_cmd == pgtm_pkg::CMD_LOAD_C) || cmd.emit;
  assign c_wr_addr = cmd.emit ? {cmd.row, cmd.col} : {in_row, in_col};
  assign c_wr_data = cmd.emit ? result : in_value;

  always_ff @(posedge clk) begin
    if (c_wr_en) begin
      c_mem[c_wr_addr] <= c_wr_data;
    end
    if (cmd.issue) begin
      c_q_r <= c_mem[{cmd.row, cmd.col}];
    end
  end

  // MAC pipeline: read, multiply, accumulate
  assign acc_nxt = (cmd.clr_acc ? '0 : acc_r) +
                   (v2_r ? {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} : '0);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(a_q_r) * $signed(b_q_r));
    acc_r  <= acc_nxt;
    if (cmd.scale_en) begin
      scaled_r <= SCL_W'($signed(alpha) * $signed(acc_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // Drop the low fraction bits (floor), add the base, saturate to 32 bits
  assign shifted  = scaled_r[SCL_W-1:pgtm_pkg::FRAC_W];
  assign base     = overwrite ? '0 : c_q_r;
  assign total    = {shifted[SH_W-1], shifted} +
                    {{(SUM_W-pgtm_pkg::CVAL_W){base[pgtm_pkg::CVAL_W-1]}}, base};
  assign in_range = (&total[SUM_W-1:pgtm_pkg::CVAL_W-1]) |
                    (~|total[SUM_W-1:pgtm_pkg::CVAL_W-1]);

  always_comb begin
    if (in_range) begin
      result = total[pgtm_pkg::CVAL_W-1:0];
    end else if (total[SUM_W-1]) begin
      result = {1'b1, {(pgtm_pkg::CVAL_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(pgtm_pkg::CVAL_W-1){1'b1}}};
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_value_r <= result;
      out_last_r  <= cmd.last;
    end
  end

  assign stat.pipe_empty = ~v1_r & ~v2_r;
  assign stat.out_free   = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/packed_gemm_tile_mac_top.sv
// ----------------------------------------------------------------------------
// packed_gemm_tile_mac_top: packed GEMM tile multiply-accumulate
// Loads packed A/B words and C entries, then on a compute command updates
// C[r][c] = base + trunc8(alpha * sum_k A(r,k)*B(k,c)), saturated, and streams
// every updated entry out column by column.
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  in_*     | slave     | tuser: command; tdata: packed_index, row, col, value
//  out_*    | master    | tdata: row, col, value; tlast: final tile entry
//  cfg_*    | APB slave | rows, cols, depth, alpha, overwrite at 4*index
//
//  Load commands (A word, B word, C entry) transfer one per cycle while idle.
//  A compute holds in_tready low until its last entry sits in the output
//  register; each entry takes bk read/multiply steps through the single MAC,
//  then a pipeline drain, scale and sum/write-back, plus any wait of the
//  output register on out_tready.
//  Reset (rst_n, synchronous, active low) restores the configuration register
//  defaults and clears the sequencer and valid flags; the A, B and C stores
//  hold undefined data until written. A stalled output holds its entry; the
//  sequencer stalls before write-back.
`default_nettype none

module packed_gemm_tile_mac_top #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned MAX_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [6:0] packed_index, [9:7] row_index, [12:10] col_index, [44:13] value
  input  wire logic [pgtm_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] command
  input  wire logic [pgtm_pkg::CMD_W-1:0]          in_tuser,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] out_row, [5:3] out_col, [37:6] out_value
  output logic      [pgtm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                     out_tlast,
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [pgtm_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [pgtm_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic      [pgtm_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  pgtm_pkg::pgtm_cmd_t            cmd;
  pgtm_pkg::pgtm_stat_t           stat;
  logic [pgtm_pkg::SIZE_W-1:0]    bm;
  logic [pgtm_pkg::SIZE_W-1:0]    bn;
  logic [pgtm_pkg::DEPTH_W-1:0]   bk;
  logic [pgtm_pkg::WORD_W-1:0]    alpha;
  logic                           overwrite;
  logic [pgtm_pkg::LINE_W-1:0]    res_row;
  logic [pgtm_pkg::LINE_W-1:0]    res_col;
  logic [pgtm_pkg::CVAL_W-1:0]    res_value;

  // Zero wait states on the configuration port
  assign cfg_pready = 1'b1;

  pgtm_cfg #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .bm        (bm),
    .bn        (bn),
    .bk        (bk),
    .alpha     (alpha),
    .overwrite (overwrite)
  );

  pgtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .bm       (bm),
    .bn       (bn),
    .bk       (bk),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgtm_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (in_tuser),
    .in_pidx   (in_tdata[6:0]),
    .in_row    (in_tdata[9:7]),
    .in_col    (in_tdata[12:10]),
    .in_value  (in_tdata[44:13]),
    .bm        (bm),
    .bn        (bn),
    .bk        (bk),
    .alpha     (alpha),
    .overwrite (overwrite),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_value (res_value),
    .out_last  (out_tlast)
  );

  // Pack the result fields, pad to whole bytes
  assign out_tdata = {2'b00, res_value, res_col, res_row};

endmodule

`default_nettype wire

>>> hw/rtl/pgtm_checker.sv
// ----------------------------------------------------------------------------
// pgtm_checker: port-level checks for the packed GEMM tile MAC
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtm_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  input  wire logic                                in_tready,
  input  wire logic [pgtm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [pgtm_pkg::CMD_W-1:0]          in_tuser,
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic [pgtm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                                out_tlast,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [pgtm_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [pgtm_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  input  wire logic [pgtm_pkg::APB_DATA_W-1:0]     cfg_prdata,
  input  wire logic                                cfg_pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed or dropped");

  // A compute transfer closes the input until the tile is done
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == pgtm_pkg::CMD_COMPUTE |=> !in_tready)
    else $error("input accepted during compute");

  // Loads never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != pgtm_pkg::CMD_COMPUTE && !out_tvalid
    |=> !out_tvalid)
    else $error("result appeared after a load");

  // A new result only appears while the sequencer is busy
  a_result_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared outside a compute");

endmodule

bind packed_gemm_tile_mac_top pgtm_checker u_pgtm_checker (.*);

`default_nettype wire
